// ===== rtl/bdg_pkg.sv =====
// Shared types and constants for the button debounce and gesture decoder.
// No dependencies; every other file in rtl/ imports this package.
package bdg_pkg;

	localparam int NUM_BTN = 5;

	localparam int BTN_NEXT = 0;
	localparam int BTN_PREV = 1;
	localparam int BTN_UP   = 2;
	localparam int BTN_DOWN = 3;
	localparam int BTN_PLAY = 4;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_HOLD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PREV_HOLD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEXT_HOLD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd6;

	localparam logic [7:0]  DEBOUNCE_RST      = 8'd5;
	localparam logic [15:0] PLAY_HOLD_RST     = 16'd2000;
	localparam logic [15:0] DOUBLE_TAP_RST    = 16'd400;
	localparam logic [15:0] PREV_HOLD_RST     = 16'd800;
	localparam logic [15:0] NEXT_HOLD_RST     = 16'd800;
	localparam logic [15:0] REPEAT_DELAY_RST  = 16'd400;
	localparam logic [15:0] REPEAT_PERIOD_RST = 16'd150;

	typedef struct packed {
		logic level_next;
		logic level_prev;
		logic level_up;
		logic level_down;
		logic level_play;
	} item_t;

	typedef struct packed {
		logic next_press;
		logic prev_press;
		logic up_step;
		logic down_step;
		logic play_tap;
		logic play_double;
		logic sleep_request;
		logic prev_hold;
		logic next_hold;
	} result_t;

	typedef struct packed {
		logic [NUM_BTN-1:0] fall;
		logic [NUM_BTN-1:0] rise;
		logic [NUM_BTN-1:0] level;
	} edge_t;

	typedef struct packed {
		logic [15:0] play_hold;
		logic [15:0] double_tap;
		logic [15:0] prev_hold;
		logic [15:0] next_hold;
		logic [15:0] repeat_delay;
		logic [15:0] repeat_period;
	} cfg_t;

endpackage

// ===== rtl/bdg_debounce.sv =====
// Per-button saturating stability counters that turn raw levels into press/release edges.
// Depends on bdg_pkg.
module bdg_debounce import bdg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [NUM_BTN-1:0] raw,
	input  logic [7:0]         debounce_count,
	output edge_t              edges
);

	logic [NUM_BTN-1:0] sample_q;
	logic [NUM_BTN-1:0] stable_q;
	logic [7:0]         count_q [NUM_BTN];
	logic [7:0]         count_n [NUM_BTN];
	logic [NUM_BTN-1:0] fire;

	always_comb begin
		for (int i = 0; i < NUM_BTN; i++) begin
			if (raw[i] == sample_q[i]) begin
				count_n[i] = (count_q[i] < COUNT_MAX) ? count_q[i] + 8'd1 : count_q[i];
			end else begin
				count_n[i] = 8'd0;
			end
			fire[i]        = (count_n[i] == debounce_count) && (raw[i] != stable_q[i]);
			edges.fall[i]  = fire[i] & ~raw[i];
			edges.rise[i]  = fire[i] & raw[i];
			edges.level[i] = fire[i] ? raw[i] : stable_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '1;
			stable_q <= '1;
			for (int i = 0; i < NUM_BTN; i++) begin
				count_q[i] <= DEBOUNCE_RST;
			end
		end else if (advance) begin
			sample_q <= raw;
			stable_q <= edges.level;
			for (int i = 0; i < NUM_BTN; i++) begin
				count_q[i] <= count_n[i];
			end
		end
	end

endmodule

// ===== rtl/bdg_gesture.sv =====
// Tick counter and gesture state: play tap/double/sleep, prev/next press/hold, volume repeat.
// Depends on bdg_pkg; takes edges and stable levels from bdg_debounce.
module bdg_gesture import bdg_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  cfg_t    cfg,
	input  edge_t   edges,
	output result_t result
);

	logic [TIME_BITS-1:0] tick_q;
	logic [TIME_BITS-1:0] play_start_q;
	logic [TIME_BITS-1:0] last_tap_q;
	logic                 tap_valid_q;

	logic [TIME_BITS-1:0] hold_start_q [2];
	logic [1:0]           hold_active_q;
	logic [1:0]           hold_done_q;
	logic [TIME_BITS-1:0] rep_q [2];
	logic [1:0]           vol_active_q;

	logic                 play_long;
	logic                 play_dbl_ok;

	logic [1:0]           h_fall, h_rise, h_level;
	logic [TIME_BITS-1:0] h_limit [2];
	logic [TIME_BITS-1:0] h_start_n [2];
	logic [1:0]           h_active_n, h_done_n, h_held, h_press;

	logic [1:0]           v_fall, v_rise, v_level;
	logic [TIME_BITS-1:0] v_rep_n [2];
	logic [TIME_BITS-1:0] v_diff [2];
	logic [TIME_BITS-1:0] v_rep_next [2];
	logic [1:0]           v_active_n, v_repeat, v_step;

	assign h_fall  = {edges.fall[BTN_NEXT], edges.fall[BTN_PREV]};
	assign h_rise  = {edges.rise[BTN_NEXT], edges.rise[BTN_PREV]};
	assign h_level = {edges.level[BTN_NEXT], edges.level[BTN_PREV]};
	assign h_limit[0] = TIME_BITS'(cfg.prev_hold);
	assign h_limit[1] = TIME_BITS'(cfg.next_hold);

	assign v_fall  = {edges.fall[BTN_DOWN], edges.fall[BTN_UP]};
	assign v_rise  = {edges.rise[BTN_DOWN], edges.rise[BTN_UP]};
	assign v_level = {edges.level[BTN_DOWN], edges.level[BTN_UP]};

	assign play_long   = (tick_q - play_start_q) >= TIME_BITS'(cfg.play_hold);
	assign play_dbl_ok = tap_valid_q && ((tick_q - last_tap_q) <= TIME_BITS'(cfg.double_tap));

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			h_start_n[h]  = h_fall[h] ? tick_q : hold_start_q[h];
			h_active_n[h] = h_fall[h] | hold_active_q[h];
			h_done_n[h]   = ~h_fall[h] & hold_done_q[h];
			h_held[h]     = !h_done_n[h] && h_active_n[h] && !h_level[h] &&
				((tick_q - h_start_n[h]) >= h_limit[h]);
			h_press[h]    = h_rise[h] && !h_done_n[h];

			v_rep_n[h]    = v_fall[h] ? tick_q + TIME_BITS'(cfg.repeat_delay) : rep_q[h];
			v_active_n[h] = v_fall[h] | vol_active_q[h];
			v_diff[h]     = tick_q - v_rep_n[h];
			v_repeat[h]   = v_active_n[h] && !v_level[h] && !v_diff[h][TIME_BITS-1];
			v_step[h]     = v_fall[h] | v_repeat[h];
			v_rep_next[h] = v_repeat[h] ? tick_q + TIME_BITS'(cfg.repeat_period) : v_rep_n[h];
		end
	end

	always_comb begin
		result.next_press    = h_press[1];
		result.prev_press    = h_press[0];
		result.up_step       = v_step[0];
		result.down_step     = v_step[1];
		result.play_tap      = edges.rise[BTN_PLAY] && !play_long;
		result.play_double   = edges.rise[BTN_PLAY] && !play_long && play_dbl_ok;
		result.sleep_request = edges.rise[BTN_PLAY] && play_long;
		result.prev_hold     = h_held[0];
		result.next_hold     = h_held[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= TIME_BITS'(1);
			play_start_q  <= '0;
			last_tap_q    <= '0;
			tap_valid_q   <= 1'b0;
			hold_active_q <= '0;
			hold_done_q   <= '0;
			vol_active_q  <= '0;
			for (int h = 0; h < 2; h++) begin
				hold_start_q[h] <= '0;
				rep_q[h]        <= '0;
			end
		end else if (advance) begin
			tick_q <= tick_q + TIME_BITS'(1);
			if (edges.fall[BTN_PLAY]) begin
				play_start_q <= tick_q;
			end
			if (result.play_double) begin
				tap_valid_q <= 1'b0;
				last_tap_q  <= '0;
			end else if (result.play_tap) begin
				tap_valid_q <= 1'b1;
				last_tap_q  <= tick_q;
			end
			hold_done_q   <= h_done_n | h_held;
			hold_active_q <= h_active_n & ~h_rise;
			vol_active_q  <= v_active_n & ~v_rise;
			for (int h = 0; h < 2; h++) begin
				hold_start_q[h] <= h_start_n[h];
				rep_q[h]        <= v_rep_next[h];
			end
		end
	end

endmodule

// ===== rtl/button_debounce_gesture_decoder.sv =====
// Five-button debounce and gesture decoder. Each item is one 1 ms tick of five active-low
// raw levels; each item yields exactly one result in the next cycle, held in a single output
// register. An item is taken in every clock while that register is empty or being read, so
// the sustained rate is one item per cycle; a stalled reader holds back at most one item.
// Configuration writes take effect from the next item. Depends on bdg_pkg, bdg_debounce,
// bdg_gesture.
module button_debounce_gesture_decoder import bdg_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic               advance;
	logic [NUM_BTN-1:0] raw;
	logic [7:0]         debounce_q;
	cfg_t               cfg_q;
	edge_t              edges;
	result_t            result_n;
	result_t            result_q;
	logic               result_valid_q;

	assign item_ready   = !result_valid_q || result_ready;
	assign advance      = item_valid && item_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		raw           = '0;
		raw[BTN_NEXT] = item.level_next;
		raw[BTN_PREV] = item.level_prev;
		raw[BTN_UP]   = item.level_up;
		raw[BTN_DOWN] = item.level_down;
		raw[BTN_PLAY] = item.level_play;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q          <= DEBOUNCE_RST;
			cfg_q.play_hold     <= PLAY_HOLD_RST;
			cfg_q.double_tap    <= DOUBLE_TAP_RST;
			cfg_q.prev_hold     <= PREV_HOLD_RST;
			cfg_q.next_hold     <= NEXT_HOLD_RST;
			cfg_q.repeat_delay  <= REPEAT_DELAY_RST;
			cfg_q.repeat_period <= REPEAT_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:      debounce_q          <= cfg_data[7:0];
				REG_PLAY_HOLD:     cfg_q.play_hold     <= cfg_data;
				REG_DOUBLE_TAP:    cfg_q.double_tap    <= cfg_data;
				REG_PREV_HOLD:     cfg_q.prev_hold     <= cfg_data;
				REG_NEXT_HOLD:     cfg_q.next_hold     <= cfg_data;
				REG_REPEAT_DELAY:  cfg_q.repeat_delay  <= cfg_data;
				REG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data;
				default: ;
			endcase
		end
	end

	bdg_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.raw            (raw),
		.debounce_count (debounce_q),
		.edges          (edges)
	);

	bdg_gesture #(
		.TIME_BITS (TIME_BITS)
	) u_gesture (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg_q),
		.edges   (edges),
		.result  (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= advance || (result_valid_q && !result_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted item produced no result");

	a_double_is_tap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.play_double || result.play_tap))
		else $error("double tap without tap");

	a_tap_or_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.play_tap && result.sleep_request))
		else $error("tap and sleep in one item");

	a_hold_excl_press: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.next_hold && result.next_press) &&
			!(result.prev_hold && result.prev_press))
		else $error("hold and press in one item");

endmodule
